// ===== sv/powerpc_integer_execute_unit_defines.svh =====
// Assertion macros for the integer execute unit.
`ifndef POWERPC_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define POWERPC_INTEGER_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PIEXU_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PIEXU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/piexu_pkg.sv =====
`default_nettype none
package piexu_pkg;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [3:0]  CR_LT    = 4'h8;
   localparam logic [3:0]  CR_GT    = 4'h4;
   localparam logic [3:0]  CR_EQ    = 4'h2;

   typedef enum logic [5:0] {
      ACT_ADDI = 6'd0, ACT_ADDIC, ACT_ADDIC_RC, ACT_ADDIS, ACT_ANDI_RC, ACT_ANDIS_RC,
      ACT_CMPI, ACT_CMPLI, ACT_MULLI, ACT_ORI, ACT_ORIS, ACT_SUBFIC, ACT_TWI, ACT_XORI,
      ACT_XORIS, ACT_RLWIMI, ACT_RLWINM, ACT_RLWNM, ACT_AND, ACT_ANDC, ACT_CMP, ACT_CMPL,
      ACT_CNTLZW, ACT_EQV, ACT_EXTSB, ACT_EXTSH, ACT_NAND, ACT_NOR, ACT_OR, ACT_ORC,
      ACT_SLW, ACT_SRAW, ACT_SRAWI, ACT_SRW, ACT_TW, ACT_XOR, ACT_ADD, ACT_ADDC, ACT_ADDE,
      ACT_ADDME, ACT_ADDZE, ACT_DIVW, ACT_DIVWU, ACT_MULHW, ACT_MULHWU, ACT_MULLW, ACT_NEG,
      ACT_SUBF, ACT_SUBFC, ACT_SUBFE, ACT_SUBFME, ACT_SUBFZE
   } action_type;

   typedef enum logic [2:0] {
      UNIT_NONE, UNIT_ALU, UNIT_MUL, UNIT_DIV, UNIT_CLZ
   } unit_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_READ_RD, ST_EXEC, ST_MUL_FIX, ST_DIV, ST_DIV_FIX, ST_CLZ,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      unit_type unit;
      logic     wr;
      logic     rec;
      logic     cmp;
   } decode_type;

   typedef struct packed {
      action_type  action;
      decode_type  dec;
      logic [4:0]  rd;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [15:0] imm;
      logic [4:0]  sh;
      logic [4:0]  mb;
      logic [4:0]  me;
      logic [2:0]  crf;
      logic [4:0]  to;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [31:0] value;
      logic        wr;
      logic        carry;
      logic [3:0]  cr;
      logic        wcr;
      logic        trap;
   } result_type;

   function automatic decode_type decode_action(action_type act, logic rc);
      decode_type d;
      d.unit = UNIT_ALU;
      d.wr   = 1'b1;
      d.rec  = 1'b0;
      d.cmp  = 1'b0;
      case (act)
         ACT_ADDI, ACT_ADDIC, ACT_ADDIS, ACT_ORI, ACT_ORIS, ACT_SUBFIC, ACT_XORI,
         ACT_XORIS: begin
            d.rec = 1'b0;
         end
         ACT_ADDIC_RC, ACT_ANDI_RC, ACT_ANDIS_RC: begin
            d.rec = 1'b1;
         end
         ACT_CMPI, ACT_CMPLI, ACT_CMP, ACT_CMPL: begin
            d.wr  = 1'b0;
            d.cmp = 1'b1;
         end
         ACT_TWI, ACT_TW: begin
            d.wr = 1'b0;
         end
         ACT_MULLI: begin
            d.unit = UNIT_MUL;
         end
         ACT_MULHW, ACT_MULHWU, ACT_MULLW: begin
            d.unit = UNIT_MUL;
            d.rec  = rc;
         end
         ACT_DIVW, ACT_DIVWU: begin
            d.unit = UNIT_DIV;
            d.rec  = rc;
         end
         ACT_CNTLZW: begin
            d.unit = UNIT_CLZ;
            d.rec  = rc;
         end
         ACT_RLWIMI, ACT_RLWINM, ACT_RLWNM, ACT_AND, ACT_ANDC, ACT_EQV, ACT_EXTSB,
         ACT_EXTSH, ACT_NAND, ACT_NOR, ACT_OR, ACT_ORC, ACT_SLW, ACT_SRAW, ACT_SRAWI,
         ACT_SRW, ACT_XOR, ACT_ADD, ACT_ADDC, ACT_ADDE, ACT_ADDME, ACT_ADDZE, ACT_NEG,
         ACT_SUBF, ACT_SUBFC, ACT_SUBFE, ACT_SUBFME, ACT_SUBFZE: begin
            d.rec = rc;
         end
         default: begin
            d.unit = UNIT_NONE;
            d.wr   = 1'b0;
         end
      endcase
      return d;
   endfunction

   function automatic logic [3:0] cond_field(logic lt, logic gt, logic so);
      logic [3:0] f;
      f = lt ? CR_LT : (gt ? CR_GT : CR_EQ);
      return f | {3'b000, so};
   endfunction

   function automatic logic [3:0] lead_zeros8(logic [7:0] x);
      logic [3:0] n;
      logic       hit;
      n   = 4'd0;
      hit = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!hit) begin
            if (x[i]) begin
               hit = 1'b1;
            end else begin
               n = n + 4'd1;
            end
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== sv/piexu_front.sv =====
`default_nettype none
module piexu_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [5:0]                 req_action,
   input  wire logic [4:0]                 req_target_reg,
   input  wire logic [4:0]                 req_source_a_reg,
   input  wire logic [4:0]                 req_source_b_reg,
   input  wire logic [15:0]                req_immediate,
   input  wire logic [4:0]                 req_shift_amount,
   input  wire logic [4:0]                 req_mask_begin,
   input  wire logic [4:0]                 req_mask_end,
   input  wire logic                       req_record,
   input  wire logic [2:0]                 req_cr_target,
   input  wire logic [4:0]                 req_trap_conditions,
   input  wire logic                       head_pop,
   output piexu_pkg::queue_head_type       head
);
   import piexu_pkg::*;

   item_type   q_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   item_type   new_item;
   logic       do_push, do_pop;

   always_comb begin
      new_item.action = action_type'(req_action);
      new_item.dec    = decode_action(action_type'(req_action), req_record);
      new_item.rd     = req_target_reg;
      new_item.ra     = req_source_a_reg;
      new_item.rb     = req_source_b_reg;
      new_item.imm    = req_immediate;
      new_item.sh     = req_shift_amount;
      new_item.mb     = req_mask_begin;
      new_item.me     = req_mask_end;
      new_item.crf    = req_cr_target;
      new_item.to     = req_trap_conditions;
   end

   assign full       = (cnt_ff == 2'd2);
   assign do_push    = push && !full;
   assign do_pop     = head_pop && (cnt_ff != 2'd0);
   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = q_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= ~rptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/piexu_regfile.sv =====
`default_nettype none
module piexu_regfile (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        re,
   input  wire logic [4:0]  raddr_a,
   input  wire logic [4:0]  raddr_b,
   output logic [31:0]      rdata_a,
   output logic [31:0]      rdata_b,
   input  wire logic        we,
   input  wire logic [4:0]  waddr,
   input  wire logic [31:0] wdata
);
   logic [31:0] mem [32];
   logic [31:0] vld_ff;
   logic [31:0] mem_a_ff, mem_b_ff;
   logic        vld_a_ff, vld_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         mem_a_ff <= mem[raddr_a];
         mem_b_ff <= mem[raddr_b];
         vld_a_ff <= vld_ff[raddr_a];
         vld_b_ff <= vld_ff[raddr_b];
      end
   end

   // never-written entries read as zero
   assign rdata_a = vld_a_ff ? mem_a_ff : '0;
   assign rdata_b = vld_b_ff ? mem_b_ff : '0;

endmodule
`default_nettype wire

// ===== sv/piexu_back.sv =====
`default_nettype none
`include "powerpc_integer_execute_unit_defines.svh"
module piexu_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       summary_overflow,
   input  wire piexu_pkg::queue_head_type  head,
   output logic                            head_pop,
   input  wire logic                       pop,
   output logic                            empty,
   output piexu_pkg::result_type           rsp_head
);
   import piexu_pkg::*;

   back_state_type state_ff, state_in;
   item_type       item_ff;
   logic [31:0]    a_ff, b_ff, t_ff, res_ff;
   logic [3:0]     cmp_cr_ff;
   logic           trap_ff, ca_we_ff, ca_val_ff, carry_ff;
   logic [63:0]    prod_ff;
   logic [31:0]    q_ff, rem_ff, dvs_ff;
   logic           neg_ff;
   logic [4:0]     div_cnt_ff;
   logic [31:0]    clz_x_ff;
   logic [5:0]     clz_cnt_ff;
   logic [1:0]     clz_step_ff;
   logic [3:0]     cr_file_ff [8];

   result_type     oq_ff [2];
   logic           oq_wptr_ff, oq_rptr_ff;
   logic [1:0]     oq_cnt_ff;
   logic           oq_full, oq_push, oq_pop;

   logic           rf_re, rf_we;
   logic [4:0]     rf_raddr_a, rf_raddr_b;
   logic [31:0]    rdata_a, rdata_b;

   piexu_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .re      (rf_re),
      .raddr_a (rf_raddr_a),
      .raddr_b (rf_raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b),
      .we      (rf_we),
      .waddr   (item_ff.rd),
      .wdata   (res_ff)
   );

   // execute datapath
   logic [31:0] simm, uimm, himm, ra_z;
   logic [31:0] add_x, add_y, cmp_y, mul_y;
   logic        add_c;
   logic [32:0] sum33;
   logic        lt_s, gt_s, lt_u, gt_u, eq;
   logic [4:0]  rot_n;
   logic [63:0] rot_dbl;
   logic [31:0] rot, mask_lo, mask_hi, mask;
   logic [5:0]  sra_n;
   logic [31:0] sra_res;
   logic        sra_ca;
   logic [31:0] alu_res;
   logic        alu_ca_we, alu_ca;
   logic [3:0]  alu_cr;
   logic        alu_trap;
   logic        div_special;
   logic [31:0] div_special_val;
   logic [63:0] prod_in;
   logic [32:0] rem_sh, diff;
   logic [3:0]  done_cr;
   logic        done_wcr;
   result_type  done_res;

   always_comb begin
      simm = {{16{item_ff.imm[15]}}, item_ff.imm};
      uimm = {16'h0000, item_ff.imm};
      himm = {item_ff.imm, 16'h0000};
      ra_z = (item_ff.ra == 5'd0) ? '0 : a_ff;

      add_x = a_ff;
      add_y = b_ff;
      add_c = 1'b0;
      case (item_ff.action)
         ACT_ADDI:                  begin add_x = ra_z;  add_y = simm; end
         ACT_ADDIS:                 begin add_x = ra_z;  add_y = himm; end
         ACT_ADDIC, ACT_ADDIC_RC:   begin add_y = simm; end
         ACT_SUBFIC:                begin add_x = ~a_ff; add_y = simm; add_c = 1'b1; end
         ACT_ADDE:                  begin add_c = carry_ff; end
         ACT_ADDME:                 begin add_y = ALL_ONES; add_c = carry_ff; end
         ACT_ADDZE:                 begin add_y = '0; add_c = carry_ff; end
         ACT_NEG:                   begin add_x = ~a_ff; add_y = '0; add_c = 1'b1; end
         ACT_SUBF, ACT_SUBFC:       begin add_x = ~a_ff; add_c = 1'b1; end
         ACT_SUBFE:                 begin add_x = ~a_ff; add_c = carry_ff; end
         ACT_SUBFME:                begin add_x = ~a_ff; add_y = ALL_ONES; add_c = carry_ff; end
         ACT_SUBFZE:                begin add_x = ~a_ff; add_y = '0; add_c = carry_ff; end
         default:                   begin add_c = 1'b0; end
      endcase
      sum33 = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_c};

      if (item_ff.action == ACT_CMPI || item_ff.action == ACT_TWI) begin
         cmp_y = simm;
      end else if (item_ff.action == ACT_CMPLI) begin
         cmp_y = uimm;
      end else begin
         cmp_y = b_ff;
      end
      lt_s = $signed(a_ff) < $signed(cmp_y);
      gt_s = $signed(cmp_y) < $signed(a_ff);
      lt_u = a_ff < cmp_y;
      gt_u = a_ff > cmp_y;
      eq   = a_ff == cmp_y;

      rot_n   = (item_ff.action == ACT_RLWNM) ? b_ff[4:0] : item_ff.sh;
      rot_dbl = {a_ff, a_ff} << rot_n;
      rot     = rot_dbl[63:32];
      mask_lo = ALL_ONES >> item_ff.mb;
      mask_hi = (ALL_ONES >> item_ff.me) >> 1;
      mask    = (item_ff.me < item_ff.mb) ? ~(mask_lo ^ mask_hi) : (mask_lo ^ mask_hi);

      sra_n = (item_ff.action == ACT_SRAW) ? b_ff[5:0] : {1'b0, item_ff.sh};
      if (sra_n[5]) begin
         sra_res = {32{a_ff[31]}};
         sra_ca  = a_ff[31];
      end else begin
         sra_res = 32'($signed(a_ff) >>> sra_n[4:0]);
         sra_ca  = a_ff[31] && ((a_ff & ~(ALL_ONES << sra_n[4:0])) != '0);
      end

      alu_res   = '0;
      alu_ca_we = 1'b0;
      alu_ca    = sum33[32];
      alu_cr    = cond_field(lt_s, gt_s, summary_overflow);
      alu_trap  = 1'b0;
      case (item_ff.action)
         ACT_ADDI, ACT_ADDIS, ACT_ADD, ACT_NEG, ACT_SUBF: alu_res = sum33[31:0];
         ACT_ADDIC, ACT_ADDIC_RC, ACT_SUBFIC, ACT_ADDC, ACT_ADDE, ACT_ADDME, ACT_ADDZE,
         ACT_SUBFC, ACT_SUBFE, ACT_SUBFME, ACT_SUBFZE: begin
            alu_res   = sum33[31:0];
            alu_ca_we = 1'b1;
         end
         ACT_ANDI_RC:  alu_res = a_ff & uimm;
         ACT_ANDIS_RC: alu_res = a_ff & himm;
         ACT_ORI:      alu_res = a_ff | uimm;
         ACT_ORIS:     alu_res = a_ff | himm;
         ACT_XORI:     alu_res = a_ff ^ uimm;
         ACT_XORIS:    alu_res = a_ff ^ himm;
         ACT_CMPI, ACT_CMP:   alu_cr = cond_field(lt_s, gt_s, summary_overflow);
         ACT_CMPLI, ACT_CMPL: alu_cr = cond_field(lt_u, gt_u, summary_overflow);
         ACT_TWI, ACT_TW: begin
            alu_trap = (lt_s && item_ff.to[4]) || (gt_s && item_ff.to[3]) ||
                       (eq && item_ff.to[2]) || (lt_u && item_ff.to[1]) ||
                       (gt_u && item_ff.to[0]);
         end
         ACT_RLWIMI:   alu_res = (t_ff & ~mask) | (rot & mask);
         ACT_RLWINM, ACT_RLWNM: alu_res = rot & mask;
         ACT_AND:      alu_res = a_ff & b_ff;
         ACT_ANDC:     alu_res = a_ff & ~b_ff;
         ACT_EQV:      alu_res = ~(a_ff ^ b_ff);
         ACT_EXTSB:    alu_res = {{24{a_ff[7]}}, a_ff[7:0]};
         ACT_EXTSH:    alu_res = {{16{a_ff[15]}}, a_ff[15:0]};
         ACT_NAND:     alu_res = ~(a_ff & b_ff);
         ACT_NOR:      alu_res = ~(a_ff | b_ff);
         ACT_OR:       alu_res = a_ff | b_ff;
         ACT_ORC:      alu_res = a_ff | ~b_ff;
         ACT_XOR:      alu_res = a_ff ^ b_ff;
         ACT_SLW:      alu_res = b_ff[5] ? '0 : (a_ff << b_ff[4:0]);
         ACT_SRW:      alu_res = b_ff[5] ? '0 : (a_ff >> b_ff[4:0]);
         ACT_SRAW, ACT_SRAWI: begin
            alu_res   = sra_res;
            alu_ca_we = 1'b1;
            alu_ca    = sra_ca;
         end
         default:      alu_res = '0;
      endcase

      div_special = (item_ff.dec.unit == UNIT_DIV) &&
                    ((b_ff == '0) ||
                     (item_ff.action == ACT_DIVW && a_ff == SIGN_BIT && b_ff == ALL_ONES));
      div_special_val = (item_ff.action == ACT_DIVW && b_ff == '0 && a_ff[31]) ?
                        ALL_ONES : '0;

      mul_y   = (item_ff.action == ACT_MULLI) ? simm : b_ff;
      prod_in = a_ff * mul_y;

      rem_sh = {rem_ff, q_ff[31]};
      diff   = rem_sh - {1'b0, dvs_ff};

      done_wcr = item_ff.dec.cmp || item_ff.dec.rec;
      done_cr  = item_ff.dec.cmp ? cmp_cr_ff :
                 cond_field(res_ff[31], (res_ff != '0) && !res_ff[31], summary_overflow);
      done_res.value = item_ff.dec.wr ? res_ff : '0;
      done_res.wr    = item_ff.dec.wr;
      done_res.carry = ca_we_ff ? ca_val_ff : carry_ff;
      done_res.cr    = done_wcr ? done_cr : 4'd0;
      done_res.wcr   = done_wcr;
      done_res.trap  = trap_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (item_ff.action == ACT_RLWIMI) ? ST_READ_RD : ST_EXEC;
         end
         ST_READ_RD: state_in = ST_EXEC;
         ST_EXEC: begin
            case (item_ff.dec.unit)
               UNIT_MUL: state_in = ST_MUL_FIX;
               UNIT_DIV: state_in = div_special ? ST_DONE : ST_DIV;
               UNIT_CLZ: state_in = ST_CLZ;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_MUL_FIX: state_in = ST_DONE;
         ST_DIV: begin
            if (div_cnt_ff == 5'd0) begin
               state_in = ST_DIV_FIX;
            end
         end
         ST_DIV_FIX: state_in = ST_DONE;
         ST_CLZ: begin
            if (clz_x_ff[31:24] != 8'd0 || clz_step_ff == 2'd3) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!oq_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_pop   = (state_ff == ST_IDLE) && head.valid;
      rf_re      = head_pop || (state_ff == ST_READ && item_ff.action == ACT_RLWIMI);
      rf_raddr_a = (state_ff == ST_IDLE) ? head.item.ra : item_ff.rd;
      rf_raddr_b = head.item.rb;
      oq_push    = (state_ff == ST_DONE) && !oq_full;
      rf_we      = oq_push && item_ff.dec.wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         carry_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            cr_file_ff[i] <= 4'd0;
         end
      end else begin
         state_ff <= state_in;
         if (oq_push) begin
            carry_ff <= done_res.carry;
            if (item_ff.dec.cmp) begin
               cr_file_ff[item_ff.crf] <= done_cr;
            end else if (item_ff.dec.rec) begin
               cr_file_ff[0] <= done_cr;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (head_pop) begin
               item_ff <= head.item;
            end
         end
         ST_READ: begin
            a_ff <= rdata_a;
            b_ff <= rdata_b;
         end
         ST_READ_RD: t_ff <= rdata_a;
         ST_EXEC: begin
            res_ff    <= div_special ? div_special_val : alu_res;
            cmp_cr_ff <= alu_cr;
            trap_ff   <= alu_trap;
            ca_we_ff  <= alu_ca_we;
            ca_val_ff <= alu_ca;
            prod_ff   <= prod_in;
            neg_ff    <= (item_ff.action == ACT_DIVW) && (a_ff[31] ^ b_ff[31]);
            q_ff      <= (item_ff.action == ACT_DIVW && a_ff[31]) ? (~a_ff + 32'd1) : a_ff;
            dvs_ff    <= (item_ff.action == ACT_DIVW && b_ff[31]) ? (~b_ff + 32'd1) : b_ff;
            rem_ff    <= '0;
            div_cnt_ff  <= 5'd31;
            clz_x_ff    <= a_ff;
            clz_cnt_ff  <= 6'd0;
            clz_step_ff <= 2'd0;
         end
         ST_MUL_FIX: begin
            case (item_ff.action)
               ACT_MULHW: res_ff <= prod_ff[63:32] - (a_ff[31] ? b_ff : '0) -
                                    (b_ff[31] ? a_ff : '0);
               ACT_MULHWU: res_ff <= prod_ff[63:32];
               default:    res_ff <= prod_ff[31:0];
            endcase
         end
         ST_DIV: begin
            q_ff       <= {q_ff[30:0], ~diff[32]};
            rem_ff     <= diff[32] ? rem_sh[31:0] : diff[31:0];
            div_cnt_ff <= div_cnt_ff - 5'd1;
         end
         ST_DIV_FIX: res_ff <= neg_ff ? (~q_ff + 32'd1) : q_ff;
         ST_CLZ: begin
            if (clz_x_ff[31:24] == 8'd0 && clz_step_ff != 2'd3) begin
               clz_x_ff    <= {clz_x_ff[23:0], 8'd0};
               clz_cnt_ff  <= clz_cnt_ff + 6'd8;
               clz_step_ff <= clz_step_ff + 2'd1;
            end else begin
               res_ff <= {26'd0, clz_cnt_ff + {2'b00, lead_zeros8(clz_x_ff[31:24])}};
            end
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

   // result queue
   assign oq_full  = (oq_cnt_ff == 2'd2);
   assign empty    = (oq_cnt_ff == 2'd0);
   assign oq_pop   = pop && !empty;
   assign rsp_head = oq_ff[oq_rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wptr_ff <= 1'b0;
         oq_rptr_ff <= 1'b0;
         oq_cnt_ff  <= 2'd0;
      end else begin
         if (oq_push) begin
            oq_wptr_ff <= ~oq_wptr_ff;
         end
         if (oq_pop) begin
            oq_rptr_ff <= ~oq_rptr_ff;
         end
         oq_cnt_ff <= oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wptr_ff] <= done_res;
      end
   end

   `PIEXU_ASSERT_IMPL(a_push_done, clock, reset, oq_push, state_ff == ST_DONE, "push outside done")
   `PIEXU_ASSERT_IMPL(a_rf_write, clock, reset, rf_we, oq_push && item_ff.dec.wr, "stray rf write")
   `PIEXU_ASSERT_NEXT(a_div_end, clock, reset, state_ff == ST_DIV && div_cnt_ff == 5'd0, state_ff == ST_DIV_FIX, "divider overrun")
   `PIEXU_ASSERT_IMPL(a_oq_bound, clock, reset, 1'b1, oq_cnt_ff <= 2'd2, "result queue overflow")
   `PIEXU_ASSERT_NEXT(a_take_head, clock, reset, head_pop, state_ff == ST_READ, "request not read")

endmodule
`default_nettype wire

// ===== sv/powerpc_integer_execute_unit.sv =====
`default_nettype none
// Integer execute unit: one decoded 32-bit integer instruction per request,
// against a 32-entry register file, the carry bit and eight condition fields.
// Requests enter a two-deep queue and are executed one at a time; results
// leave through a two-deep queue. Logical, add, rotate, shift, compare and
// trap forms read, execute and finish (rlwimi adds a read of its target),
// multiplies add a fix-up step, cntlzw scans a byte per step, and divides
// take one quotient bit per cycle in the shared divider (divide by zero and
// the overflowing divide skip it). The register file reads zero until written.
module powerpc_integer_execute_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [5:0]  req_action,
   input  wire logic [4:0]  req_target_reg,
   input  wire logic [4:0]  req_source_a_reg,
   input  wire logic [4:0]  req_source_b_reg,
   input  wire logic [15:0] req_immediate,
   input  wire logic [4:0]  req_shift_amount,
   input  wire logic [4:0]  req_mask_begin,
   input  wire logic [4:0]  req_mask_end,
   input  wire logic        req_record,
   input  wire logic [2:0]  req_cr_target,
   input  wire logic [4:0]  req_trap_conditions,
   input  wire logic        pop,
   output logic             empty,
   output logic [31:0]      rsp_written_value,
   output logic             rsp_writes_register,
   output logic             rsp_carry_out,
   output logic [3:0]       rsp_cr_value,
   output logic             rsp_writes_cr,
   output logic             rsp_trap_taken,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);
   import piexu_pkg::*;

   logic           so_ff;
   queue_head_type head;
   logic           head_pop;
   result_type     rsp_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         so_ff <= 1'b0;
      end else if (csr_write_enable) begin
         so_ff <= csr_write_data;
      end
   end

   piexu_front u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_action          (req_action),
      .req_target_reg      (req_target_reg),
      .req_source_a_reg    (req_source_a_reg),
      .req_source_b_reg    (req_source_b_reg),
      .req_immediate       (req_immediate),
      .req_shift_amount    (req_shift_amount),
      .req_mask_begin      (req_mask_begin),
      .req_mask_end        (req_mask_end),
      .req_record          (req_record),
      .req_cr_target       (req_cr_target),
      .req_trap_conditions (req_trap_conditions),
      .head_pop            (head_pop),
      .head                (head)
   );

   piexu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .summary_overflow (so_ff),
      .head             (head),
      .head_pop         (head_pop),
      .pop              (pop),
      .empty            (empty),
      .rsp_head         (rsp_head)
   );

   assign rsp_written_value   = rsp_head.value;
   assign rsp_writes_register = rsp_head.wr;
   assign rsp_carry_out       = rsp_head.carry;
   assign rsp_cr_value        = rsp_head.cr;
   assign rsp_writes_cr       = rsp_head.wcr;
   assign rsp_trap_taken      = rsp_head.trap;

endmodule
`default_nettype wire

// ===== tb/sv/tb_powerpc_integer_execute_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_powerpc_integer_execute_unit;
   import piexu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [5:0]  action;
      logic [4:0]  rd;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [15:0] imm;
      logic [4:0]  sh;
      logic [4:0]  mb;
      logic [4:0]  me;
      logic        rc;
      logic [2:0]  crf;
      logic [4:0]  to;
   } request_type;

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic pop;
   logic empty;
   request_type req;
   logic [31:0] rsp_written_value;
   logic rsp_writes_register;
   logic rsp_carry_out;
   logic [3:0] rsp_cr_value;
   logic rsp_writes_cr;
   logic rsp_trap_taken;
   logic csr_write_enable;
   logic csr_write_data;

   request_type pending_requests[$];
   result_type expected_results[$];
   logic [31:0] model_regs[32];
   logic model_carry;
   logic model_so;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_cycles;
   int errors;
   int requests_sent;
   int results_seen;
   int quiet_cycles;

   powerpc_integer_execute_unit dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_action          (req.action),
      .req_target_reg      (req.rd),
      .req_source_a_reg    (req.ra),
      .req_source_b_reg    (req.rb),
      .req_immediate       (req.imm),
      .req_shift_amount    (req.sh),
      .req_mask_begin      (req.mb),
      .req_mask_end        (req.me),
      .req_record          (req.rc),
      .req_cr_target       (req.crf),
      .req_trap_conditions (req.to),
      .pop                 (pop),
      .empty               (empty),
      .rsp_written_value   (rsp_written_value),
      .rsp_writes_register (rsp_writes_register),
      .rsp_carry_out       (rsp_carry_out),
      .rsp_cr_value        (rsp_cr_value),
      .rsp_writes_cr       (rsp_writes_cr),
      .rsp_trap_taken      (rsp_trap_taken),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic logic [3:0] classify(logic lt, logic gt);
      return (lt ? 4'h8 : (gt ? 4'h4 : 4'h2)) | {3'b000, model_so};
   endfunction

   function automatic logic [31:0] rotate_left(logic [31:0] v, logic [4:0] n);
      return (v << n) | (n == 0 ? 32'h0 : v >> (6'd32 - n));
   endfunction

   function automatic logic [31:0] rotate_mask(logic [4:0] mb, logic [4:0] me);
      logic [31:0] m;
      m = (ALL_ONES >> mb) ^ (me < 5'd31 ? (ALL_ONES >> (me + 6'd1)) : 32'h0);
      return (me < mb) ? ~m : m;
   endfunction

   function automatic logic [31:0] shift_algebraic(logic [31:0] v, logic [5:0] n);
      logic neg;
      neg = v[31];
      if (n >= 6'd32) begin
         model_carry = neg;
         return neg ? ALL_ONES : 32'h0;
      end
      model_carry = neg && ((v & ((32'h1 << n) - 1)) != 0);
      return $unsigned($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] add_carry(logic [31:0] a, logic [31:0] b, logic c);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b} + {32'h0, c};
      model_carry = s[32];
      return s[31:0];
   endfunction

   function automatic logic trap_hit(logic [31:0] a, logic [31:0] b, logic [4:0] to);
      return (signed_less(a, b) && to[4]) || (signed_less(b, a) && to[3]) ||
             (a == b && to[2]) || (a < b && to[1]) || (a > b && to[0]);
   endfunction

   function automatic result_type execute_instruction(request_type r);
      result_type o;
      logic [31:0] a, b, simm, uimm, hi_imm, res;
      logic [63:0] p;
      logic cin, wr, cmp, rec, trap;
      logic [3:0] crv;
      a = model_regs[r.ra];
      b = model_regs[r.rb];
      simm = {{16{r.imm[15]}}, r.imm};
      uimm = {16'h0, r.imm};
      hi_imm = {r.imm, 16'h0};
      cin = model_carry;
      res = 0;
      crv = 0;
      wr = 1;
      cmp = 0;
      rec = 0;
      trap = 0;
      case (r.action)
         ACT_ADDI: res = (r.ra != 0 ? a : 32'h0) + simm;
         ACT_ADDIC: res = add_carry(a, simm, 0);
         ACT_ADDIC_RC: begin res = add_carry(a, simm, 0); rec = 1; end
         ACT_ADDIS: res = (r.ra != 0 ? a : 32'h0) + hi_imm;
         ACT_ANDI_RC: begin res = a & uimm; rec = 1; end
         ACT_ANDIS_RC: begin res = a & hi_imm; rec = 1; end
         ACT_CMPI: begin
            wr = 0; cmp = 1; crv = classify(signed_less(a, simm), signed_less(simm, a));
         end
         ACT_CMPLI: begin wr = 0; cmp = 1; crv = classify(a < uimm, a > uimm); end
         ACT_MULLI: res = a * simm;
         ACT_ORI: res = a | uimm;
         ACT_ORIS: res = a | hi_imm;
         ACT_SUBFIC: res = add_carry(~a, simm, 1);
         ACT_TWI: begin wr = 0; trap = trap_hit(a, simm, r.to); end
         ACT_XORI: res = a ^ uimm;
         ACT_XORIS: res = a ^ hi_imm;
         ACT_RLWIMI: begin
            res = (model_regs[r.rd] & ~rotate_mask(r.mb, r.me)) |
                  (rotate_left(a, r.sh) & rotate_mask(r.mb, r.me));
            rec = r.rc;
         end
         ACT_RLWINM: begin res = rotate_left(a, r.sh) & rotate_mask(r.mb, r.me); rec = r.rc; end
         ACT_RLWNM: begin
            res = rotate_left(a, b[4:0]) & rotate_mask(r.mb, r.me); rec = r.rc;
         end
         ACT_AND: begin res = a & b; rec = r.rc; end
         ACT_ANDC: begin res = a & ~b; rec = r.rc; end
         ACT_CMP: begin
            wr = 0; cmp = 1; crv = classify(signed_less(a, b), signed_less(b, a));
         end
         ACT_CMPL: begin wr = 0; cmp = 1; crv = classify(a < b, a > b); end
         ACT_CNTLZW: begin
            res = 32;
            for (int i = 31; i >= 0; i--) begin
               if (a[i] && res == 32) res = 31 - i;
            end
            rec = r.rc;
         end
         ACT_EQV: begin res = ~(a ^ b); rec = r.rc; end
         ACT_EXTSB: begin res = {{24{a[7]}}, a[7:0]}; rec = r.rc; end
         ACT_EXTSH: begin res = {{16{a[15]}}, a[15:0]}; rec = r.rc; end
         ACT_NAND: begin res = ~(a & b); rec = r.rc; end
         ACT_NOR: begin res = ~(a | b); rec = r.rc; end
         ACT_OR: begin res = a | b; rec = r.rc; end
         ACT_ORC: begin res = a | ~b; rec = r.rc; end
         ACT_SLW: begin res = b[5] ? 32'h0 : a << b[4:0]; rec = r.rc; end
         ACT_SRAW: begin res = shift_algebraic(a, b[5:0]); rec = r.rc; end
         ACT_SRAWI: begin res = shift_algebraic(a, {1'b0, r.sh}); rec = r.rc; end
         ACT_SRW: begin res = b[5] ? 32'h0 : a >> b[4:0]; rec = r.rc; end
         ACT_TW: begin wr = 0; trap = trap_hit(a, b, r.to); end
         ACT_XOR: begin res = a ^ b; rec = r.rc; end
         ACT_ADD: begin res = a + b; rec = r.rc; end
         ACT_ADDC: begin res = add_carry(a, b, 0); rec = r.rc; end
         ACT_ADDE: begin res = add_carry(a, b, cin); rec = r.rc; end
         ACT_ADDME: begin res = add_carry(a, ALL_ONES, cin); rec = r.rc; end
         ACT_ADDZE: begin res = add_carry(a, 0, cin); rec = r.rc; end
         ACT_DIVW: begin
            if (b == 0) res = a[31] ? ALL_ONES : 32'h0;
            else if (a == SIGN_BIT && b == ALL_ONES) res = 0;
            else begin
               res = (a[31] ? -a : a) / (b[31] ? -b : b);
               if (a[31] ^ b[31]) res = -res;
            end
            rec = r.rc;
         end
         ACT_DIVWU: begin res = (b != 0) ? a / b : 32'h0; rec = r.rc; end
         ACT_MULHW: begin
            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            res = p[63:32]; rec = r.rc;
         end
         ACT_MULHWU: begin p = {32'h0, a} * {32'h0, b}; res = p[63:32]; rec = r.rc; end
         ACT_MULLW: begin res = a * b; rec = r.rc; end
         ACT_NEG: begin res = -a; rec = r.rc; end
         ACT_SUBF: begin res = b - a; rec = r.rc; end
         ACT_SUBFC: begin res = add_carry(~a, b, 1); rec = r.rc; end
         ACT_SUBFE: begin res = add_carry(~a, b, cin); rec = r.rc; end
         ACT_SUBFME: begin res = add_carry(~a, ALL_ONES, cin); rec = r.rc; end
         ACT_SUBFZE: begin res = add_carry(~a, 0, cin); rec = r.rc; end
         default: wr = 0;
      endcase
      if (wr) model_regs[r.rd] = res;
      else res = 0;
      if (!cmp && rec) crv = classify(res[31], res != 0 && !res[31]);
      o.value = res;
      o.wr = wr;
      o.carry = model_carry;
      o.cr = crv;
      o.wcr = cmp || rec;
      o.trap = trap;
      return o;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int k;
      r = request_type'({$urandom, $urandom});
      k = $urandom_range(0, 99);
      if (k < 90) r.action = $urandom_range(0, 51);
      else if (k < 93) r.action = $urandom_range(52, 63);
      if ($urandom_range(0, 3) == 0) r.ra = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) r.rb = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) r.rd = $urandom_range(0, 3);
      case ($urandom_range(0, 7))
         0: r.imm = 16'h0000;
         1: r.imm = 16'hFFFF;
         2: r.imm = 16'h8000;
         3: r.imm = $urandom_range(0, 40);
         default: ;
      endcase
      return r;
   endfunction

   function automatic request_type make_request(action_type act, logic [4:0] rd,
                                               logic [4:0] ra, logic [4:0] rb,
                                               logic [15:0] imm);
      request_type r;
      r = '0;
      r.action = act;
      r.rd = rd;
      r.ra = ra;
      r.rb = rb;
      r.imm = imm;
      r.rc = 1;
      r.to = 5'h1F;
      r.sh = 5'd31;
      r.mb = 5'd28;
      r.me = 5'd3;
      r.crf = 3'd7;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0 || push)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_summary_overflow(logic value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_so = value;
   endtask

   task automatic run_phase(int count, int s_pct, int r_pct, bit pressure);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      if (pressure) hold_off_cycles = 200;
      repeat (count) pending_requests.push_back(random_request());
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            requests_sent++;
            expected_results.push_back(execute_instruction(req));
         end
         if ((!push || !full) && pending_requests.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            push <= 1'b1;
            req <= pending_requests.pop_front();
         end else if (!push || !full) begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t unexpected result value=%h", $time, rsp_written_value);
            end else begin
               result_type e;
               e = expected_results.pop_front();
               if (rsp_written_value !== e.value || rsp_writes_register !== e.wr ||
                   rsp_carry_out !== e.carry || rsp_cr_value !== e.cr ||
                   rsp_writes_cr !== e.wcr || rsp_trap_taken !== e.trap) begin
                  errors++;
                  $display("%0t mismatch expected %h/%b/%b/%h/%b/%b actual %h/%b/%b/%h/%b/%b",
                           $time, e.value, e.wr, e.carry, e.cr, e.wcr, e.trap,
                           rsp_written_value, rsp_writes_register, rsp_carry_out,
                           rsp_cr_value, rsp_writes_cr, rsp_trap_taken);
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog expired", $time);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req = '0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      model_so = 0;
      model_carry = 0;
      foreach (model_regs[i]) model_regs[i] = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_cycles = 0;
      errors = 0;
      requests_sent = 0;
      results_seen = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_summary_overflow(1'b1);
      // seed registers with extremes
      pending_requests.push_back(make_request(ACT_ADDIS, 1, 0, 0, 16'h8000));
      pending_requests.push_back(make_request(ACT_ADDI, 2, 0, 0, 16'hFFFF));
      pending_requests.push_back(make_request(ACT_ADDI, 3, 0, 0, 16'h7FFF));
      pending_requests.push_back(make_request(ACT_DIVW, 4, 1, 2, 0));
      pending_requests.push_back(make_request(ACT_DIVW, 5, 2, 0, 0));
      pending_requests.push_back(make_request(ACT_DIVWU, 6, 3, 0, 0));
      pending_requests.push_back(make_request(ACT_SRAW, 7, 1, 3, 0));
      pending_requests.push_back(make_request(ACT_SRAWI, 8, 2, 0, 0));
      pending_requests.push_back(make_request(ACT_SLW, 9, 2, 3, 0));
      pending_requests.push_back(make_request(ACT_SRW, 10, 2, 3, 0));
      pending_requests.push_back(make_request(ACT_RLWINM, 11, 2, 0, 0));
      pending_requests.push_back(make_request(ACT_RLWIMI, 11, 3, 0, 0));
      pending_requests.push_back(make_request(ACT_ADDE, 12, 2, 2, 0));
      pending_requests.push_back(make_request(ACT_SUBFZE, 13, 0, 0, 0));
      pending_requests.push_back(make_request(ACT_CNTLZW, 14, 0, 0, 0));
      pending_requests.push_back(make_request(ACT_CMP, 0, 1, 3, 0));
      pending_requests.push_back(make_request(ACT_CMPLI, 0, 2, 0, 16'hFFFF));
      pending_requests.push_back(make_request(ACT_TW, 0, 1, 2, 0));
      pending_requests.push_back(make_request(ACT_MULHW, 15, 1, 2, 0));
      pending_requests.push_back(make_request(action_type'(6'd63), 0, 0, 0, 0));
      for (int i = 0; i < 52; i++)
         pending_requests.push_back(make_request(action_type'(i), 0, 1, 2, 16'h8001));
      wait_drained();
      run_phase(95, 0, 0, 0);
      write_summary_overflow(1'b0);
      run_phase(95, 47, 0, 1);
      write_summary_overflow(1'b1);
      run_phase(95, 0, 47, 0);
      write_summary_overflow(1'b0);
      run_phase(95, 29, 29, 0);
      $display("Ran %0d requests over all 52 operations, %0d results checked,", requests_sent,
               results_seen);
      $display("with both summary-overflow settings, random stalls and a backpressure hold.");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
